>>> sv/mmeu_pkg.sv
// Shared constants and types for the move machine execute unit.
package mmeu_pkg;

   // Field widths of one request and of the byte machine
   localparam int DATA_W = 8;
   localparam int ADDR_W = 16;
   localparam int MODE_W = 3;
   localparam int OPND_W = 16;

   // Register file shape: registers A..Z
   localparam int REG_COUNT = 26;
   localparam int REG_AW = $clog2(REG_COUNT);

   // Default data memory depth
   localparam int MEM_DEPTH_DEF = 65536;

   // Addressing modes
   localparam logic [MODE_W-1:0] MODE_IMM     = 3'd0;
   localparam logic [MODE_W-1:0] MODE_REG     = 3'd1;
   localparam logic [MODE_W-1:0] MODE_IND     = 3'd2;
   localparam logic [MODE_W-1:0] MODE_IND_IMM = 3'd3;
   localparam logic [MODE_W-1:0] MODE_IND_REG = 3'd4;
   localparam logic [MODE_W-1:0] MODE_ABS     = 3'd5;

   // Special registers in register mode
   localparam logic [OPND_W-1:0] REG_I = 16'd8;
   localparam logic [OPND_W-1:0] REG_O = 16'd14;
   localparam logic [OPND_W-1:0] REG_Z = 16'd25;

   // Register file write port
   typedef struct packed {
      logic              en;
      logic [REG_AW-1:0] addr;
      logic [DATA_W-1:0] data;
   } rf_wr_type;

endpackage

>>> sv/move_machine_execute_unit.sv
// Top level of the move machine execute unit: two-stage pipeline over the memories.
//
// Executes one decoded move per request on a byte machine with 26 byte
// registers and a MEM_DEPTH byte data memory.
// Request channel (req_): source and target mode in tuser, operands,
// offsets and the next input byte in tdata. Result channel (rsp_): one
// status word per request with input consumed, emit flag and byte, halt
// and fault flags.
// A request passes through stage 1, stage 2 and the output register, and
// a new one is taken only once the last has left stage 1. Stage 1 reads the
// source base registers from the register file; stage 2 reads the
// target base registers and the source byte from data memory; the write
// back lands at the edge that loads the result register, so the next
// request is taken at that same edge.
// Reset: a clearing pass writes zero to every data memory entry and every
// register, one entry a cycle; req_tready stays low until it is done.
// Stall: a result waits in the output register; the stage behind it holds
// its write back and req_tready drops until the result is taken.
module move_machine_execute_unit
   import mmeu_pkg::*;
#(
   parameter int MEM_DEPTH = MEM_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // Request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   // [15:0] source_operand, [31:16] source_offset, [47:32] target_operand,
   // [63:48] target_offset, [71:64] next_input_byte
   input  logic [71:0] req_tdata,
   // [2:0] source_mode, [5:3] target_mode
   input  logic [5:0]  req_tuser,
   // Result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [0] input_consumed, [1] emit_valid, [9:2] emit_byte, [10] halted,
   // [11] fault, [15:12] zero
   output logic [15:0] rsp_tdata
);

   localparam int MEM_AW = $clog2(MEM_DEPTH);

   // Clearing pass
   logic              clr_active_ff, clr_active_in;
   logic [MEM_AW-1:0] clr_idx_ff, clr_idx_in;

   // Stage 1: source registers read
   logic              s1_valid_ff, s1_valid_in;
   logic [MODE_W-1:0] s1_smode_ff, s1_tmode_ff;
   logic [OPND_W-1:0] s1_sop_ff, s1_soff_ff, s1_top_ff, s1_toff_ff;
   logic [DATA_W-1:0] s1_inbyte_ff;

   // Stage 2: target registers and source byte read
   logic              s2_valid_ff, s2_valid_in;
   logic              s2_fault_ff, s2_src_mem_ff, s2_consumed_ff;
   logic [DATA_W-1:0] s2_src_val_ff;
   logic [MODE_W-1:0] s2_tmode_ff;
   logic [OPND_W-1:0] s2_top_ff, s2_toff_ff;

   // Output register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [15:0]       rsp_data_ff;

   // Handshake and flow
   logic accept, s1_adv, s2_done, out_free;

   // Memory ports
   logic              rf_rd_en;
   logic [REG_AW-1:0] rf_rd_addr0, rf_rd_addr1;
   logic [DATA_W-1:0] rf_rd_data0, rf_rd_data1;
   rf_wr_type         rf_wr;
   logic              dm_rd_en, dm_wr_en;
   logic [MEM_AW-1:0] dm_rd_addr, dm_wr_addr;
   logic [DATA_W-1:0] dm_rd_data, dm_wr_data;

   // Stage 1 decode
   logic              s1_src_ok, s1_tgt_ok, s1_fault, s1_src_mem, s1_consumed;
   logic [DATA_W-1:0] s1_src_val;
   logic [ADDR_W-1:0] s1_src_raw;
   logic [MEM_AW-1:0] s1_src_addr;

   // Stage 2 execute
   logic [DATA_W-1:0] s2_val;
   logic [ADDR_W-1:0] s2_tgt_raw;
   logic [MEM_AW-1:0] s2_tgt_addr;
   logic              s2_tgt_reg, s2_emit, s2_halt, s2_rf_wr, s2_dm_wr;

   // Flow control: stage 1 and stage 2 never hold requests at once
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign s2_done    = s2_valid_ff && out_free;
   assign s1_adv     = s1_valid_ff && !s2_valid_ff;
   assign req_tready = !clr_active_ff && !s1_valid_ff && (!s2_valid_ff || out_free);
   assign accept     = req_tvalid && req_tready;

   // Register file reads: source bases at accept, target bases on advance
   assign rf_rd_en    = accept || s1_adv;
   assign rf_rd_addr0 = accept ? req_tdata[REG_AW-1:0]    : s1_top_ff[REG_AW-1:0];
   assign rf_rd_addr1 = accept ? req_tdata[16+REG_AW-1:16] : s1_toff_ff[REG_AW-1:0];

   // Check the source and target operands
   always_comb begin
      unique case (s1_smode_ff)
         MODE_IMM, MODE_ABS:               s1_src_ok = 1'b1;
         MODE_REG, MODE_IND, MODE_IND_IMM: s1_src_ok = s1_sop_ff < OPND_W'(REG_COUNT);
         MODE_IND_REG: s1_src_ok = (s1_sop_ff < OPND_W'(REG_COUNT)) &&
                                   (s1_soff_ff < OPND_W'(REG_COUNT));
         default:                          s1_src_ok = 1'b0;
      endcase
      unique case (s1_tmode_ff)
         MODE_ABS:                         s1_tgt_ok = 1'b1;
         MODE_REG, MODE_IND, MODE_IND_IMM: s1_tgt_ok = s1_top_ff < OPND_W'(REG_COUNT);
         MODE_IND_REG: s1_tgt_ok = (s1_top_ff < OPND_W'(REG_COUNT)) &&
                                   (s1_toff_ff < OPND_W'(REG_COUNT));
         default:                          s1_tgt_ok = 1'b0;
      endcase
      s1_fault = !(s1_src_ok && s1_tgt_ok);
   end

   // Form the source value or the source address
   always_comb begin
      unique case (s1_smode_ff)
         MODE_IND:     s1_src_raw = ADDR_W'(rf_rd_data0);
         MODE_IND_IMM: s1_src_raw = ADDR_W'(rf_rd_data0) + s1_soff_ff;
         MODE_IND_REG: s1_src_raw = ADDR_W'(rf_rd_data0) + ADDR_W'(rf_rd_data1);
         default:      s1_src_raw = s1_sop_ff;
      endcase
      s1_src_mem  = (s1_smode_ff >= MODE_IND) && (s1_smode_ff <= MODE_ABS);
      s1_consumed = !s1_fault && (s1_smode_ff == MODE_REG) && (s1_sop_ff == REG_I);
      if (s1_smode_ff == MODE_IMM) begin
         s1_src_val = s1_sop_ff[DATA_W-1:0];
      end else if (s1_sop_ff == REG_I) begin
         s1_src_val = s1_inbyte_ff;
      end else begin
         s1_src_val = rf_rd_data0;
      end
   end

   mmeu_addr_mod #(
      .MEM_DEPTH (MEM_DEPTH),
      .MEM_AW    (MEM_AW)
   ) u_src_addr (
      .raw_addr (s1_src_raw),
      .mem_addr (s1_src_addr)
   );

   // Execute: pick the value, form the target address, decide the write
   always_comb begin
      s2_val = s2_src_mem_ff ? dm_rd_data : s2_src_val_ff;
      unique case (s2_tmode_ff)
         MODE_IND:     s2_tgt_raw = ADDR_W'(rf_rd_data0);
         MODE_IND_IMM: s2_tgt_raw = ADDR_W'(rf_rd_data0) + s2_toff_ff;
         MODE_IND_REG: s2_tgt_raw = ADDR_W'(rf_rd_data0) + ADDR_W'(rf_rd_data1);
         default:      s2_tgt_raw = s2_top_ff;
      endcase
      s2_tgt_reg = !s2_fault_ff && (s2_tmode_ff == MODE_REG);
      s2_emit    = s2_tgt_reg && (s2_top_ff == REG_O);
      s2_halt    = s2_tgt_reg && (s2_top_ff == REG_Z) && (s2_val != '0);
      s2_rf_wr   = s2_tgt_reg && (s2_top_ff != REG_O) && (s2_top_ff != REG_Z);
      s2_dm_wr   = !s2_fault_ff && (s2_tmode_ff != MODE_REG);
   end

   mmeu_addr_mod #(
      .MEM_DEPTH (MEM_DEPTH),
      .MEM_AW    (MEM_AW)
   ) u_tgt_addr (
      .raw_addr (s2_tgt_raw),
      .mem_addr (s2_tgt_addr)
   );

   // Write ports: the clearing pass owns them after reset
   always_comb begin
      if (clr_active_ff) begin
         rf_wr.en   = clr_idx_ff < MEM_AW'(REG_COUNT);
         rf_wr.addr = clr_idx_ff[REG_AW-1:0];
         rf_wr.data = '0;
         dm_wr_en   = 1'b1;
         dm_wr_addr = clr_idx_ff;
         dm_wr_data = '0;
      end else begin
         rf_wr.en   = s2_done && s2_rf_wr;
         rf_wr.addr = s2_top_ff[REG_AW-1:0];
         rf_wr.data = s2_val;
         dm_wr_en   = s2_done && s2_dm_wr;
         dm_wr_addr = s2_tgt_addr;
         dm_wr_data = s2_val;
      end
   end

   assign dm_rd_en   = s1_adv;
   assign dm_rd_addr = s1_src_addr;

   mmeu_reg_file u_reg_file (
      .clock    (clock),
      .rd_en    (rf_rd_en),
      .rd_addr0 (rf_rd_addr0),
      .rd_addr1 (rf_rd_addr1),
      .rd_data0 (rf_rd_data0),
      .rd_data1 (rf_rd_data1),
      .wr       (rf_wr)
   );

   mmeu_data_mem #(
      .MEM_DEPTH (MEM_DEPTH),
      .MEM_AW    (MEM_AW)
   ) u_data_mem (
      .clock   (clock),
      .rd_en   (dm_rd_en),
      .rd_addr (dm_rd_addr),
      .rd_data (dm_rd_data),
      .wr_en   (dm_wr_en),
      .wr_addr (dm_wr_addr),
      .wr_data (dm_wr_data)
   );

   // Next control state
   always_comb begin
      clr_active_in = clr_active_ff;
      clr_idx_in    = clr_idx_ff;
      if (clr_active_ff) begin
         clr_idx_in = clr_idx_ff + 1'b1;
         if (clr_idx_ff == MEM_AW'(MEM_DEPTH - 1)) begin
            clr_active_in = 1'b0;
         end
      end

      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end

      s2_valid_in = s2_valid_ff;
      if (s1_adv) begin
         s2_valid_in = 1'b1;
      end else if (s2_done) begin
         s2_valid_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      if (s2_done) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Hold control state
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_active_ff <= 1'b1;
         clr_idx_ff    <= '0;
         s1_valid_ff   <= 1'b0;
         s2_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         clr_active_ff <= clr_active_in;
         clr_idx_ff    <= clr_idx_in;
         s1_valid_ff   <= s1_valid_in;
         s2_valid_ff   <= s2_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Advance the payload
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_smode_ff  <= req_tuser[2:0];
         s1_tmode_ff  <= req_tuser[5:3];
         s1_sop_ff    <= req_tdata[15:0];
         s1_soff_ff   <= req_tdata[31:16];
         s1_top_ff    <= req_tdata[47:32];
         s1_toff_ff   <= req_tdata[63:48];
         s1_inbyte_ff <= req_tdata[71:64];
      end
      if (s1_adv) begin
         s2_fault_ff    <= s1_fault;
         s2_src_mem_ff  <= s1_src_mem;
         s2_consumed_ff <= s1_consumed;
         s2_src_val_ff  <= s1_src_val;
         s2_tmode_ff    <= s1_tmode_ff;
         s2_top_ff      <= s1_top_ff;
         s2_toff_ff     <= s1_toff_ff;
      end
      if (s2_done) begin
         rsp_data_ff <= {4'b0000, s2_fault_ff, s2_halt,
                         s2_emit ? s2_val : {DATA_W{1'b0}}, s2_emit, s2_consumed_ff};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

>>> sv/mmeu_reg_file.sv
// Register file: two synchronous write-first read ports and one write port.
module mmeu_reg_file
   import mmeu_pkg::*;
(
   input  logic              clock,
   input  logic              rd_en,
   input  logic [REG_AW-1:0] rd_addr0,
   input  logic [REG_AW-1:0] rd_addr1,
   output logic [DATA_W-1:0] rd_data0,
   output logic [DATA_W-1:0] rd_data1,
   input  rf_wr_type         wr
);

   logic [DATA_W-1:0] regs [REG_COUNT];
   logic [DATA_W-1:0] rd_data0_ff;
   logic [DATA_W-1:0] rd_data1_ff;

   // Store the write
   always_ff @(posedge clock) begin
      if (wr.en) begin
         regs[wr.addr] <= wr.data;
      end
   end

   // Read both ports; a write to the same entry in this cycle passes through
   always_ff @(posedge clock) begin
      if (rd_en) begin
         if (wr.en && wr.addr == rd_addr0) begin
            rd_data0_ff <= wr.data;
         end else if (rd_addr0 < REG_AW'(REG_COUNT)) begin
            rd_data0_ff <= regs[rd_addr0];
         end else begin
            rd_data0_ff <= '0;
         end
         if (wr.en && wr.addr == rd_addr1) begin
            rd_data1_ff <= wr.data;
         end else if (rd_addr1 < REG_AW'(REG_COUNT)) begin
            rd_data1_ff <= regs[rd_addr1];
         end else begin
            rd_data1_ff <= '0;
         end
      end
   end

   assign rd_data0 = rd_data0_ff;
   assign rd_data1 = rd_data1_ff;

endmodule

>>> sv/mmeu_data_mem.sv
// Data memory: one synchronous write-first read port and one write port.
module mmeu_data_mem
   import mmeu_pkg::*;
#(
   parameter int MEM_DEPTH = MEM_DEPTH_DEF,
   parameter int MEM_AW    = $clog2(MEM_DEPTH)
) (
   input  logic              clock,
   input  logic              rd_en,
   input  logic [MEM_AW-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data,
   input  logic              wr_en,
   input  logic [MEM_AW-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data
);

   logic [DATA_W-1:0] mem [MEM_DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   // Store the write
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read; hold the data until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         if (wr_en && wr_addr == rd_addr) begin
            rd_data_ff <= wr_data;
         end else begin
            rd_data_ff <= mem[rd_addr];
         end
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sv/mmeu_addr_mod.sv
// Reduces a 16-bit byte address to the data memory depth.
module mmeu_addr_mod
   import mmeu_pkg::*;
#(
   parameter int MEM_DEPTH = MEM_DEPTH_DEF,
   parameter int MEM_AW    = $clog2(MEM_DEPTH)
) (
   input  logic [ADDR_W-1:0] raw_addr,
   output logic [MEM_AW-1:0] mem_addr
);

   generate
      if ((MEM_DEPTH & (MEM_DEPTH - 1)) == 0) begin : g_pow2
         // Power-of-two depth: keep the low bits
         assign mem_addr = raw_addr[MEM_AW-1:0];
      end else begin : g_recip
         localparam int SHIFT = ADDR_W + MEM_AW;
         localparam int RECIP_W = ADDR_W + 2;
         localparam longint RECIP =
            ((longint'(1) << SHIFT) + longint'(MEM_DEPTH) - 1) / longint'(MEM_DEPTH);

         logic [ADDR_W+RECIP_W-1:0] prod;
         logic [ADDR_W-1:0]         quot;
         logic [ADDR_W:0]           rem;

         // Quotient by reciprocal, then one correcting subtract
         always_comb begin
            prod = {{RECIP_W{1'b0}}, raw_addr} * (ADDR_W+RECIP_W)'(RECIP);
            quot = ADDR_W'(prod >> SHIFT);
            rem  = {1'b0, raw_addr} - (ADDR_W+1)'(quot * MEM_DEPTH);
            if (rem >= (ADDR_W+1)'(MEM_DEPTH)) begin
               rem = rem - (ADDR_W+1)'(MEM_DEPTH);
            end
         end

         assign mem_addr = rem[MEM_AW-1:0];
      end
   endgenerate

endmodule
